/* src/cei_pkg.sv */
`default_nettype none
package cei_pkg;

	localparam logic signed [31:0] MISSING = 32'shFFFF_0000;

	localparam logic [2:0] REG_EDGE   = 3'd0;
	localparam logic [2:0] REG_EVEN   = 3'd1;
	localparam logic [2:0] REG_FIRST  = 3'd2;
	localparam logic [2:0] REG_SPACE  = 3'd3;
	localparam logic [2:0] REG_DSCALE = 3'd4;
	localparam logic [2:0] REG_DOFF   = 3'd5;
	localparam logic [2:0] REG_TSCALE = 3'd6;
	localparam logic [2:0] REG_TOFF   = 3'd7;

	typedef enum logic [17:0] {
		ST_LOAD   = 18'h00001,
		ST_START  = 18'h00002,
		ST_DIVW   = 18'h00004,
		ST_EVK_W  = 18'h00008,
		ST_EVK    = 18'h00010,
		ST_SCAN_W = 18'h00020,
		ST_SCAN   = 18'h00040,
		ST_MUL    = 18'h00080,
		ST_IDIV_S = 18'h00100,
		ST_IDIV_W = 18'h00200,
		ST_BACK_W = 18'h00400,
		ST_BACK   = 18'h00800,
		ST_GEN    = 18'h01000,
		ST_GEN2   = 18'h02000,
		ST_MAPD   = 18'h04000,
		ST_MAPT   = 18'h08000,
		ST_MAPF   = 18'h10000,
		ST_DONE   = 18'h20000
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	// clamp to the signed 32 bit range
	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -50'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* src/cei_if.sv */
`default_nettype none
interface cei_curve_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_distance;
	logic signed [31:0] point_time;
	logic               last_point;

	modport source (output valid, point_distance, point_time, last_point, input ready);
	modport sink (input valid, point_distance, point_time, last_point, output ready);
endinterface

interface cei_result_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [31:0] view_distance;
	logic signed [31:0] view_time;

	modport source (output valid, found, view_distance, view_time, input ready);
	modport sink (input valid, found, view_distance, view_time, output ready);
endinterface
`default_nettype wire

/* src/cei_div.sv */
`default_nettype none
// restoring divider, one quotient bit per cycle
module cei_div (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire [63:0]       dividend,
	input  wire [31:0]       divisor,
	output cei_pkg::div_ctl_t stat,
	output logic [63:0]      quot,
	output logic [31:0]      rem
);
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] sh;
	logic [32:0] sub;
	logic        ge;

	assign sh  = {rem_q, quo_q[63]};
	assign ge  = sh >= {1'b0, dvs_q};
	assign sub = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? sub[31:0] : sh[31:0];
		end
	end

	assign stat.start = start;
	assign stat.done  = done_q;
	assign quot       = quo_q;
	assign rem        = rem_q;
endmodule
`default_nettype wire

/* src/curve_edge_intercept.sv */
// points load one per cycle while curve.ready is high; an item without last_point
// makes no result. the item with last_point starts the search, which holds
// curve.ready low: evenly spaced points take an index divide and loaded
// distances a scan point by point, plus an interpolation (shared multiplier
// then divider) and a walk back point by point.
// arst_n clears control and config registers; point memories are not cleared.
`default_nettype none
module curve_edge_intercept #(
	parameter int MAX_POINTS = 1024,
	parameter int TOLERANCE  = 1
) (
	input  wire        clk,
	input  wire        arst_n,
	cei_curve_if.sink  curve,
	cei_result_if.source result,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [4:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	// configuration registers
	logic signed [31:0] edge_q, first_q, dscale_q, doff_q, tscale_q, toff_q;
	logic               even_q;
	logic [30:0]        spacing_q;

	// point memories
	logic signed [31:0] dmem [MAX_POINTS];
	logic signed [31:0] tmem [MAX_POINTS];
	logic signed [31:0] rd_da, rd_db, rd_ta, rd_tb;

	cei_pkg::state_t state_q;
	logic [CW-1:0]   cnt_q, cnt_n, n_q, idx_q, idx_p1;
	logic            in_acc, wr_en;

	// search working registers
	logic [31:0]        del_q, num_q, den_q;
	logic signed [31:0] t0_q, tw_q, dw_q;
	logic [32:0]        mag_q;
	logic               neg_q;
	logic [63:0]        mul_q;

	// pending result and output register
	logic               found_q, out_valid_q, out_found_q;
	logic signed [31:0] vd_q, vt_q, out_vd_q, out_vt_q;

	// shared multiplier
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;

	// divider
	logic                div_start;
	logic [63:0]         div_dvd, div_quot;
	logic [31:0]         div_dvs, div_rem;
	cei_pkg::div_ctl_t   div_stat;

	logic signed [32:0] diff;
	logic signed [32:0] dd0, dt;
	logic [32:0]        ad;
	logic signed [33:0] tsum;

	assign pready = 1'b1;
	assign in_acc = curve.valid && curve.ready;
	assign curve.ready = (state_q == cei_pkg::ST_LOAD);
	assign wr_en  = in_acc && (cnt_q < CW'(MAX_POINTS));
	assign cnt_n  = wr_en ? cnt_q + 1'b1 : cnt_q;
	assign idx_p1 = idx_q + 1'b1;

	assign diff = $signed({edge_q[31], edge_q}) - $signed({first_q[31], first_q});
	assign dd0  = $signed({rd_da[31], rd_da}) - $signed({edge_q[31], edge_q});
	assign ad   = dd0[32] ? 33'(-dd0) : 33'(dd0);
	assign dt   = $signed({rd_tb[31], rd_tb}) - $signed({rd_ta[31], rd_ta});
	assign tsum = neg_q ? $signed({{2{t0_q[31]}}, t0_q}) - $signed({1'b0, div_quot[32:0]})
	                    : $signed({{2{t0_q[31]}}, t0_q}) + $signed({1'b0, div_quot[32:0]});

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q    <= '0;
			even_q    <= 1'b0;
			first_q   <= '0;
			spacing_q <= 31'd65536;
			dscale_q  <= 32'sd65536;
			doff_q    <= '0;
			tscale_q  <= 32'sd65536;
			toff_q    <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				cei_pkg::REG_EDGE:   edge_q    <= pwdata;
				cei_pkg::REG_EVEN:   even_q    <= pwdata[0];
				cei_pkg::REG_FIRST:  first_q   <= pwdata;
				cei_pkg::REG_SPACE:  spacing_q <= pwdata[30:0];
				cei_pkg::REG_DSCALE: dscale_q  <= pwdata;
				cei_pkg::REG_DOFF:   doff_q    <= pwdata;
				cei_pkg::REG_TSCALE: tscale_q  <= pwdata;
				cei_pkg::REG_TOFF:   toff_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			cei_pkg::REG_EDGE:   prdata = edge_q;
			cei_pkg::REG_EVEN:   prdata = {31'd0, even_q};
			cei_pkg::REG_FIRST:  prdata = first_q;
			cei_pkg::REG_SPACE:  prdata = {1'b0, spacing_q};
			cei_pkg::REG_DSCALE: prdata = dscale_q;
			cei_pkg::REG_DOFF:   prdata = doff_q;
			cei_pkg::REG_TSCALE: prdata = tscale_q;
			cei_pkg::REG_TOFF:   prdata = toff_q;
			default:             prdata = '0;
		endcase
	end

	// memories: one write port, two registered read ports at idx and idx+1
	always_ff @(posedge clk) begin
		if (wr_en) begin
			dmem[cnt_q[AW-1:0]] <= curve.point_distance;
			tmem[cnt_q[AW-1:0]] <= curve.point_time;
		end
		rd_da <= dmem[idx_q[AW-1:0]];
		rd_db <= dmem[idx_p1[AW-1:0]];
		rd_ta <= tmem[idx_q[AW-1:0]];
		rd_tb <= tmem[idx_p1[AW-1:0]];
	end

	// multiplier operand select, product registered
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			cei_pkg::ST_MUL: begin
				ma = $signed({1'b0, mag_q[31:0]});
				mb = $signed({1'b0, num_q});
			end
			cei_pkg::ST_GEN: begin
				ma = $signed(33'(idx_q));
				mb = $signed({2'b00, spacing_q});
			end
			cei_pkg::ST_MAPD: begin
				ma = {dscale_q[31], dscale_q};
				mb = {dw_q[31], dw_q};
			end
			cei_pkg::ST_MAPT: begin
				ma = {tscale_q[31], tscale_q};
				mb = {tw_q[31], tw_q};
			end
			default: ;
		endcase
	end
	assign mp = ma * mb;

	always_ff @(posedge clk) begin
		mul_q <= mp[63:0];
	end

	// divider feed: index divide or interpolation quotient
	always_comb begin
		div_start = 1'b0;
		div_dvd   = {32'd0, diff[31:0]};
		div_dvs   = {1'b0, spacing_q};
		if (state_q == cei_pkg::ST_START) begin
			div_start = even_q && (spacing_q != '0) && !diff[32];
		end else if (state_q == cei_pkg::ST_IDIV_S) begin
			div_start = 1'b1;
			div_dvd   = mul_q + (mag_q[32] ? {num_q, 32'd0} : 64'd0);
			div_dvs   = den_q;
		end
	end

	cei_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.stat     (div_stat),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cei_pkg::ST_LOAD;
			cnt_q       <= '0;
			n_q         <= '0;
			idx_q       <= '0;
		end else begin
			case (state_q)
				cei_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (curve.last_point) begin
							n_q     <= cnt_n;
							cnt_q   <= '0;
							idx_q   <= '0;
							state_q <= cei_pkg::ST_START;
						end else begin
							cnt_q <= cnt_n;
						end
					end
				end
				cei_pkg::ST_START: begin
					if (!even_q) begin
						state_q <= cei_pkg::ST_SCAN_W;
					end else if (div_stat.start) begin
						state_q <= cei_pkg::ST_DIVW;
					end else begin
						state_q <= cei_pkg::ST_DONE;
					end
				end
				cei_pkg::ST_DIVW: begin
					if (div_stat.done) begin
						if (div_quot >= 64'(n_q)) begin
							state_q <= cei_pkg::ST_DONE;
						end else begin
							idx_q   <= div_quot[CW-1:0];
							state_q <= cei_pkg::ST_EVK_W;
						end
					end
				end
				cei_pkg::ST_EVK_W:  state_q <= cei_pkg::ST_EVK;
				cei_pkg::ST_EVK: begin
					if (rd_ta == cei_pkg::MISSING) begin
						state_q <= cei_pkg::ST_BACK_W;
					end else if (del_q < 32'(TOLERANCE)) begin
						state_q <= cei_pkg::ST_MAPD;
					end else if (idx_p1 >= n_q) begin
						state_q <= cei_pkg::ST_DONE;
					end else begin
						state_q <= cei_pkg::ST_MUL;
					end
				end
				cei_pkg::ST_SCAN_W: state_q <= cei_pkg::ST_SCAN;
				cei_pkg::ST_SCAN: begin
					if (ad < 33'(TOLERANCE)) begin
						state_q <= (rd_ta == cei_pkg::MISSING) ? cei_pkg::ST_BACK_W
						                                        : cei_pkg::ST_MAPD;
					end else if ((idx_p1 < n_q) && (rd_da <= edge_q) && (rd_db > edge_q)) begin
						state_q <= (rd_ta == cei_pkg::MISSING) ? cei_pkg::ST_BACK_W
						                                        : cei_pkg::ST_MUL;
					end else if (idx_p1 >= n_q) begin
						state_q <= cei_pkg::ST_DONE;
					end else begin
						idx_q   <= idx_p1;
						state_q <= cei_pkg::ST_SCAN_W;
					end
				end
				cei_pkg::ST_MUL:    state_q <= cei_pkg::ST_IDIV_S;
				cei_pkg::ST_IDIV_S: state_q <= cei_pkg::ST_IDIV_W;
				cei_pkg::ST_IDIV_W: begin
					if (div_stat.done) begin
						state_q <= (tsum[31:0] == cei_pkg::MISSING) ? cei_pkg::ST_BACK_W
						                                             : cei_pkg::ST_MAPD;
					end
				end
				cei_pkg::ST_BACK_W: state_q <= cei_pkg::ST_BACK;
				cei_pkg::ST_BACK: begin
					if (rd_ta != cei_pkg::MISSING) begin
						state_q <= even_q ? cei_pkg::ST_GEN : cei_pkg::ST_MAPD;
					end else if (idx_q == '0) begin
						state_q <= cei_pkg::ST_DONE;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= cei_pkg::ST_BACK_W;
					end
				end
				cei_pkg::ST_GEN:  state_q <= cei_pkg::ST_GEN2;
				cei_pkg::ST_GEN2: state_q <= cei_pkg::ST_MAPD;
				cei_pkg::ST_MAPD: state_q <= cei_pkg::ST_MAPT;
				cei_pkg::ST_MAPT: state_q <= cei_pkg::ST_MAPF;
				cei_pkg::ST_MAPF: state_q <= cei_pkg::ST_DONE;
				cei_pkg::ST_DONE: begin
					// hand off once the output register is free
					if (!out_valid_q || result.ready) begin
						state_q <= cei_pkg::ST_LOAD;
					end
				end
				default: state_q <= cei_pkg::ST_LOAD;
			endcase
		end
	end

	// output valid: set on hand off, cleared when the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == cei_pkg::ST_DONE) && (!out_valid_q || result.ready)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			cei_pkg::ST_START: begin
				found_q <= 1'b0;
				vd_q    <= '0;
				vt_q    <= cei_pkg::MISSING;
			end
			cei_pkg::ST_DIVW: begin
				del_q <= div_rem;
			end
			cei_pkg::ST_EVK: begin
				tw_q  <= rd_ta;
				dw_q  <= edge_q;
				t0_q  <= rd_ta;
				neg_q <= dt[32];
				mag_q <= dt[32] ? 33'(-dt) : 33'(dt);
				num_q <= del_q;
				den_q <= {1'b0, spacing_q};
			end
			cei_pkg::ST_SCAN: begin
				tw_q  <= rd_ta;
				dw_q  <= edge_q;
				t0_q  <= rd_ta;
				neg_q <= dt[32];
				mag_q <= dt[32] ? 33'(-dt) : 33'(dt);
				num_q <= 32'(edge_q - rd_da);
				den_q <= 32'(rd_db - rd_da);
			end
			cei_pkg::ST_IDIV_W: begin
				tw_q <= tsum[31:0];
			end
			cei_pkg::ST_BACK: begin
				tw_q <= rd_ta;
				dw_q <= rd_da;
			end
			cei_pkg::ST_GEN2: begin
				dw_q <= cei_pkg::sat32($signed({{18{first_q[31]}}, first_q})
				                       + $signed(mul_q[49:0]));
			end
			cei_pkg::ST_MAPT: begin
				vd_q <= cei_pkg::sat32($signed({{2{mul_q[63]}}, mul_q[63:16]})
				                       + $signed({{18{doff_q[31]}}, doff_q}));
			end
			cei_pkg::ST_MAPF: begin
				vt_q    <= cei_pkg::sat32($signed({{2{mul_q[63]}}, mul_q[63:16]})
				                          + $signed({{18{toff_q[31]}}, toff_q}));
				found_q <= 1'b1;
			end
			cei_pkg::ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_found_q <= found_q;
					out_vd_q    <= vd_q;
					out_vt_q    <= vt_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid         = out_valid_q;
	assign result.found         = out_found_q;
	assign result.view_distance = out_vd_q;
	assign result.view_time     = out_vt_q;
endmodule
`default_nettype wire

/* src/cei_chk.sv */
`default_nettype none
module cei_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        curve_valid,
	input wire        curve_ready,
	input wire        curve_last,
	input wire        res_valid,
	input wire        res_ready,
	input wire        res_found,
	input wire [31:0] res_vd,
	input wire [31:0] res_vt,
	input wire        pready
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_vd) && $stable(res_vt)
		&& $stable(res_found))
		else $error("result changed while stalled");

	// not found carries the fixed payload
	a_nf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_vd == 32'd0 && res_vt == 32'hFFFF_0000)
		else $error("not found payload wrong");

	// the search item closes the input until the result is made
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		curve_valid && curve_ready && curve_last |=> !curve_ready)
		else $error("input open during search");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind curve_edge_intercept cei_chk u_cei_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.curve_valid (curve.valid),
	.curve_ready (curve.ready),
	.curve_last  (curve.last_point),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_found   (result.found),
	.res_vd      (result.view_distance),
	.res_vt      (result.view_time),
	.pready      (pready)
);
`default_nettype wire

/* verif/curve_edge_intercept_test.sv */
`default_nettype none
module curve_edge_intercept_test;

	localparam int  DEPTH      = 1024;
	localparam int  TOL        = 1;
	// no acceptance for this many cycles means the block hung: the limit leaves
	// room for a full scan of the store plus a full walk back
	localparam int  STALL_LIMIT = 40000;
	localparam int  SETTLE      = 200;

	typedef struct {
		bit               found;
		logic signed [31:0] vdist;
		logic signed [31:0] vtime;
	} intercept_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cei_curve_if  cur ();
	cei_result_if res ();

	curve_edge_intercept dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.curve   (cur),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow copy of the block's registers and point memories
	longint edge_pos, first_pos, step, dscale, doff, tscale, toff;
	bit     even_mode;
	logic signed [31:0] dist_mem [DEPTH];
	logic signed [31:0] time_mem [DEPTH];
	int     n_loaded;

	intercept_t pending_views [$];
	int     d_q [$];
	int     t_q [$];
	bit     failed;
	bit     steady;        // no idling on either side while set
	longint cycle_cnt;
	longint last_accept;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	// watchdog: nothing moving for too long
	always @(posedge clk) begin
		if (cycle_cnt - last_accept > STALL_LIMIT) begin
			$display("%0t: timeout, no item accepted for %0d cycles", $time, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// t0 + (t1 - t0) * num / den with the quotient rounded toward zero
	function automatic longint lerp_time(longint t0, longint t1, longint num, longint den);
		longint     dt;
		logic [63:0] mag;
		logic [63:0] q;
		dt  = t1 - t0;
		mag = (dt < 0) ? -dt : dt;
		q   = (mag * 64'(num)) / 64'(den);
		return (dt < 0) ? t0 - longint'(q) : t0 + longint'(q);
	endfunction

	// scale * value / 65536 (floor) + offset, saturated
	function automatic longint to_view(longint sc, longint v, longint off);
		longint p;
		p = sc * v;
		return clamp32((p >>> 16) + off);
	endfunction

	// time at the edge over the stored curve, with the walk back past missing times
	function automatic bit edge_lookup(output longint dw, output longint tw);
		longint k, t, diff, del, d0, ad;
		longint n;
		bit     hit;
		n  = n_loaded;
		t  = 0;
		k  = 0;
		dw = 0;
		tw = 0;
		if (even_mode) begin
			if (step == 0) return 0;
			diff = edge_pos - first_pos;
			k = diff / step;
			if (diff % step != 0 && diff < 0) k--;
			if (k < 0 || k >= n) return 0;
			del = diff - k * step;
			if (time_mem[k] == cei_pkg::MISSING) begin
				t = cei_pkg::MISSING;
			end else if (del < TOL) begin
				t = time_mem[k];
			end else begin
				if (k + 1 >= n) return 0;
				t = lerp_time(time_mem[k], time_mem[k+1], del, step);
			end
		end else begin
			hit = 0;
			for (k = 0; k < n; k++) begin
				d0 = dist_mem[k];
				ad = d0 - edge_pos;
				if (ad < 0) ad = -ad;
				if (ad < TOL) begin
					t = time_mem[k];
					hit = 1;
					break;
				end
				if (k + 1 < n && d0 <= edge_pos && longint'(dist_mem[k+1]) > edge_pos) begin
					if (time_mem[k] == cei_pkg::MISSING) t = cei_pkg::MISSING;
					else t = lerp_time(time_mem[k], time_mem[k+1], edge_pos - d0,
						longint'(dist_mem[k+1]) - d0);
					hit = 1;
					break;
				end
			end
			if (!hit) return 0;
		end
		dw = edge_pos;
		if (t == cei_pkg::MISSING) begin
			// back to the latest point with a real time
			for (longint i = k; i >= 0; i--) begin
				if (time_mem[i] != cei_pkg::MISSING) begin
					tw = time_mem[i];
					dw = even_mode ? clamp32(first_pos + i * step) : longint'(dist_mem[i]);
					return 1;
				end
			end
			return 0;
		end
		tw = t;
		return 1;
	endfunction

	// model one accepted point; the last one of a curve queues its intercept
	task automatic absorb_point(int d, int t, bit last);
		intercept_t r;
		longint     dw, tw;
		if (n_loaded < DEPTH) begin
			dist_mem[n_loaded] = d;
			time_mem[n_loaded] = t;
			n_loaded++;
		end
		if (last) begin
			if (edge_lookup(dw, tw)) begin
				r.found = 1;
				r.vdist = 32'(to_view(dscale, dw, doff));
				r.vtime = 32'(to_view(tscale, tw, toff));
			end else begin
				r.found = 0;
				r.vdist = 0;
				r.vtime = cei_pkg::MISSING;
			end
			pending_views.push_back(r);
			n_loaded = 0;
		end
	endtask

	// one item on the curve channel, after a random gap
	task automatic send_point(int d, int t, bit last);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			cur.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cur.valid          <= 1'b1;
		cur.point_distance <= d;
		cur.point_time     <= t;
		cur.last_point     <= last;
		// ready is stable between the falling and the next rising edge
		@(negedge clk);
		while (!cur.ready) @(negedge clk);
		@(posedge clk);
		last_accept = cycle_cnt;
		absorb_point(d, t, last);
	endtask

	// stop sending and let every queued intercept come out
	task automatic drain();
		@(posedge clk);
		cur.valid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			cei_pkg::REG_EDGE:   edge_pos  = longint'(signed'(val));
			cei_pkg::REG_EVEN:   even_mode = val[0];
			cei_pkg::REG_FIRST:  first_pos = longint'(signed'(val));
			cei_pkg::REG_SPACE:  step      = longint'(val[30:0]);
			cei_pkg::REG_DSCALE: dscale    = longint'(signed'(val));
			cei_pkg::REG_DOFF:   doff      = longint'(signed'(val));
			cei_pkg::REG_TSCALE: tscale    = longint'(signed'(val));
			cei_pkg::REG_TOFF:   toff      = longint'(signed'(val));
			default: ;
		endcase
	endtask

	task automatic add_pt(int d, int t);
		d_q.push_back(d);
		t_q.push_back(t);
	endtask

	// set the edge while idle, send the built curve, wait for its intercept
	task automatic run_curve(int edge_val);
		write_reg(cei_pkg::REG_EDGE, edge_val);
		foreach (d_q[i]) send_point(d_q[i], t_q[i], i == d_q.size() - 1);
		d_q.delete();
		t_q.delete();
		drain();
	endtask

	task automatic set_view(int ds, int dof, int ts, int tof);
		write_reg(cei_pkg::REG_DSCALE, ds);
		write_reg(cei_pkg::REG_DOFF, dof);
		write_reg(cei_pkg::REG_TSCALE, ts);
		write_reg(cei_pkg::REG_TOFF, tof);
	endtask

	// result side: random stalls, compare against the oldest expectation
	initial begin
		intercept_t want;
		int         stall;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(negedge clk);
			while (!res.valid) @(negedge clk);
			want.found = res.found;
			want.vdist = res.view_distance;
			want.vtime = res.view_time;
			@(posedge clk);
			last_accept = cycle_cnt;
			if (pending_views.size() == 0) begin
				$display("%0t: intercept with none expected: found %0d dist %0d time %0d",
					$time, want.found, want.vdist, want.vtime);
				failed = 1;
			end else begin
				intercept_t exp_v;
				exp_v = pending_views.pop_front();
				if (exp_v.found !== want.found) begin
					$display("%0t: found expected %0d actual %0d", $time, exp_v.found, want.found);
					failed = 1;
				end
				if (exp_v.vdist !== want.vdist) begin
					$display("%0t: view_distance expected %0d actual %0d",
						$time, exp_v.vdist, want.vdist);
					failed = 1;
				end
				if (exp_v.vtime !== want.vtime) begin
					$display("%0t: view_time expected %0d actual %0d",
						$time, exp_v.vtime, want.vtime);
					failed = 1;
				end
			end
		end
	end

	// loaded distances: hits, interpolation both ways, walk back, misses, extremes
	task automatic test_loaded_curves();
		add_pt(-65536, 100); add_pt(65536, 300);
		run_curve(0);
		add_pt(0, 1000); add_pt(65536, -500); add_pt(131072, 7);
		run_curve(65536);                       // exact hit on a point
		add_pt(0, 65536 * 10); add_pt(65536 * 3, 0);
		run_curve(65536);                       // falling time
		add_pt(0, 555); add_pt(65536, cei_pkg::MISSING); add_pt(131072, 9);
		run_curve(98304);                       // missing time, walk back one
		add_pt(0, cei_pkg::MISSING); add_pt(65536, cei_pkg::MISSING);
		run_curve(100);                         // nothing valid to walk back to
		add_pt(0, 5); add_pt(65536, 6);
		run_curve(200000);                      // edge past the curve
		add_pt(123, 77);
		run_curve(123);                         // single point exact
		add_pt(123, 77);
		run_curve(124);                         // single point miss
		add_pt(32'h8000_0000, 32'h7FFF_FFFF); add_pt(32'h7FFF_FFFF, 32'h8000_0000);
		run_curve(0);                           // field extremes
		add_pt(32'h8000_0000, 32'h8000_0000); add_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		run_curve(32'h7FFF_FFFE);
		add_pt(10, 1); add_pt(10, 2); add_pt(20, cei_pkg::MISSING);
		run_curve(15);                          // missing neighbor interpolated
	endtask

	// generated distances: index below, beyond, on a point, between points
	task automatic test_even_curves();
		write_reg(cei_pkg::REG_EVEN, 1);
		write_reg(cei_pkg::REG_FIRST, -65536);
		write_reg(cei_pkg::REG_SPACE, 65536);
		for (int i = 0; i < 4; i++) add_pt($urandom, 1000 * i);
		run_curve(-65536 + 2 * 65536);          // on point two
		for (int i = 0; i < 4; i++) add_pt($urandom, 1000 * i);
		run_curve(32768);                       // between points
		for (int i = 0; i < 4; i++) add_pt($urandom, 1000 * i);
		run_curve(-65537);                      // below the first point
		for (int i = 0; i < 4; i++) add_pt($urandom, 1000 * i);
		run_curve(-65536 + 3 * 65536 + 5);      // last point, no neighbor
		for (int i = 0; i < 4; i++) add_pt($urandom, 1000 * i);
		run_curve(-65536 + 4 * 65536);          // beyond
		add_pt(0, 11); add_pt(0, cei_pkg::MISSING); add_pt(0, cei_pkg::MISSING);
		run_curve(-65536 + 2 * 65536 + 9);      // walk back to point zero
		write_reg(cei_pkg::REG_FIRST, 32'h7FFF_0000);
		write_reg(cei_pkg::REG_SPACE, 32'h7FFF_FFFF);
		add_pt(0, 4); add_pt(0, cei_pkg::MISSING);
		run_curve(32'h7FFF_FFFF);
		write_reg(cei_pkg::REG_FIRST, 32'h8000_0000);
		add_pt(0, 4); add_pt(0, cei_pkg::MISSING); add_pt(0, 8);
		run_curve(32'h7FFF_FFFF);               // index on the last point, no neighbor
		write_reg(cei_pkg::REG_SPACE, 0);
		add_pt(0, 1); add_pt(0, 2);
		run_curve(0);                           // spacing zero
		write_reg(cei_pkg::REG_SPACE, 65536);
		write_reg(cei_pkg::REG_FIRST, 0);
		write_reg(cei_pkg::REG_EVEN, 0);
	endtask

	// view mapping at the scale and offset extremes, saturation included
	task automatic test_view_mapping();
		set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		add_pt(32'h8000_0000, 32'h7FFF_FFFF); add_pt(32'h7FFF_FFFF, 32'h8000_0000);
		run_curve(32'h8000_0000);
		set_view(-3, -7, 32'h8000_0000, 32'h7FFF_FFFF);
		add_pt(-5, -9); add_pt(77, 3);
		run_curve(-5);
		set_view(65536, 0, 65536, 0);
	endtask

	// more points than the store holds; the extra ones are dropped
	task automatic test_store_overflow();
		steady = 1;
		for (int i = 0; i < DEPTH + 2; i++)
			add_pt(i * 100, i == DEPTH - 1 ? cei_pkg::MISSING : i);
		run_curve((DEPTH - 1) * 100 + 50);
		steady = 0;
	endtask

	// random curves under random settings
	task automatic test_random_curves();
		int sent, n, base, d, t, edge_val, pick;
		sent = 0;
		while (sent < 30) begin
			steady = ($urandom_range(0, 7) == 0);
			pick = $urandom_range(0, 3);
			case (pick)
				0: set_view(65536, 0, 65536, 0);
				1: set_view($urandom, $urandom, $urandom, $urandom);
				2: set_view($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
					$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
					$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
					$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
				default: set_view($urandom_range(0, 200000) - 100000, $urandom_range(0, 9999),
					$urandom_range(0, 200000) - 100000, $urandom_range(0, 9999));
			endcase
			write_reg(cei_pkg::REG_EVEN, $urandom_range(0, 2) == 0);
			write_reg(cei_pkg::REG_FIRST, $urandom_range(0, 3) == 0 ? $urandom :
				$urandom_range(0, 1 << 22) - (1 << 21));
			write_reg(cei_pkg::REG_SPACE, $urandom_range(0, 4) == 0 ? $urandom :
				$urandom_range(1, 1 << 18));
			for (int c = 0; c < 8 && sent < 30; c++) begin
				n = $urandom_range(1, 12);
				base = $urandom_range(0, 1 << 22) - (1 << 21);
				d = base;
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 9) == 0) d = $urandom;          // noise
					else d = d + $urandom_range(0, 3 << 16);
					pick = $urandom_range(0, 9);
					t = pick < 3 ? cei_pkg::MISSING : pick < 5 ? $urandom :
						$urandom_range(0, 1 << 24) - (1 << 23);
					add_pt(d, t);
				end
				pick = $urandom_range(0, 9);
				if (even_mode)
					edge_val = first_pos + $urandom_range(0, n + 1) * step +
						(pick < 4 ? 0 : $urandom_range(0, 32'h7FFF_FFFF) % (step + 1)) -
						(pick == 9);
				else if (pick < 4)
					edge_val = d_q[$urandom_range(0, n - 1)];
				else if (pick < 8)
					edge_val = d_q[$urandom_range(0, n - 1)] + $urandom_range(0, 3 << 16);
				else
					edge_val = $urandom;
				sent += n;
				run_curve(edge_val);
			end
		end
		steady = 0;
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		cur.valid   = 1'b0;
		cur.point_distance = '0;
		cur.point_time     = '0;
		cur.last_point     = 1'b0;
		failed      = 0;
		steady      = 0;
		cycle_cnt   = 0;
		last_accept = 0;
		n_loaded    = 0;
		edge_pos    = 0;
		even_mode   = 0;
		first_pos   = 0;
		step        = 65536;
		dscale      = 65536;
		doff        = 0;
		tscale      = 65536;
		toff        = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_loaded_curves();
		test_even_curves();
		test_view_mapping();
		test_store_overflow();
		test_random_curves();

		drain();
		repeat (SETTLE) @(posedge clk);
		if (!failed && pending_views.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire
